/* src/timestamped_delay_line_interp_defines.svh */
// Assertion macros for the delay line block.
`ifndef TIMESTAMPED_DELAY_LINE_INTERP_DEFINES_SVH
`define TIMESTAMPED_DELAY_LINE_INTERP_DEFINES_SVH

`ifndef SYNTHESIS
`define TDLI_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("delay line assertion failed");
`define TDLI_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("delay line assertion failed");
`else
`define TDLI_ASSERT_IMP(lbl, ante, cons)
`define TDLI_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

/* src/tdli_pkg.sv */
package tdli_pkg;

    localparam int CHAN_W = 3;

    localparam logic MODE_STORE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_NEG_DELAY = 1'b1;

endpackage

/* src/timestamped_delay_line_interp.sv */
// Per-channel delay line of timestamped samples with linear interpolation.
// Store items pass through accept and memory write. Query items that resolve
// from the check alone pass through accept, check and the output handoff; a query
// within start plus delay adds one memory read. A searched query reads the newest
// entry, then, unless the target lies past it, runs the binary search at one
// time-memory read per cycle (up to about log2(RING_DEPTH)+1 reads), then reads
// the bracketing pair. Where an interpolation is needed, a shift-add multiplier
// runs and then a restoring divider. One item is worked at a time; the result
// sits in an output register, so the next item is accepted while it waits.
// Sample memories hold no reset value and need no clearing pass.
`include "timestamped_delay_line_interp_defines.svh"

module timestamped_delay_line_interp #(
    parameter int NUM_CHANNELS = 8,
    parameter int RING_DEPTH   = 1024,
    parameter int TIME_WIDTH   = 48,
    parameter int VALUE_WIDTH  = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [TIME_WIDTH-1:0]               cfg_wr_data,   // start_time
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // sample_value, sample_time, delay_amount, delay_limit, zero pad
    input  logic [((VALUE_WIDTH+3*TIME_WIDTH+7)/8)*8-1:0] s_tdata,
    // mode, channel
    input  logic [tdli_pkg::CHAN_W:0]           s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // delayed_value, status, zero pad
    output logic [((VALUE_WIDTH+1+7)/8)*8-1:0]  m_tdata
);

    localparam int TW    = TIME_WIDTH;
    localparam int VW    = VALUE_WIDTH;
    localparam int AW    = $clog2(RING_DEPTH);
    localparam int CW    = $clog2(RING_DEPTH + 1);
    localparam int CHW   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int MEM_D = NUM_CHANNELS * RING_DEPTH;
    localparam int MAW   = $clog2(MEM_D);
    localparam int P     = VW + TW;
    localparam int PCW   = $clog2(P + 1);
    localparam int OUT_W = ((VW + 1 + 7) / 8) * 8;

    typedef enum logic [3:0] {
        ST_IDLE, ST_STORE, ST_CHECK, ST_RDFIRST, ST_RDLAST, ST_SEARCH,
        ST_RDI, ST_RDI1, ST_EVAL, ST_MUL, ST_DIV, ST_SAT, ST_DONE
    } state_t;

    state_t state_reg;

    logic [TW-1:0] start_reg;
    logic [tdli_pkg::CHAN_W-1:0] ch_reg;
    logic [VW-1:0] cur_reg;
    logic [TW-1:0] now_reg, delay_reg, limit_reg, ts_reg;
    logic [TW-1:0] t0_reg, t1_reg;
    logic [VW-1:0] o0_reg, o1_reg;
    logic [CW-1:0] len_reg, lo_reg, hi_reg, i_reg;
    logic [AW-1:0] head_reg [NUM_CHANNELS];
    logic [CW-1:0] count_reg [NUM_CHANNELS];
    logic [P-1:0]  a_reg, prod_reg, q_reg;
    logic [TW-1:0] b_reg, dvs_reg, rem_reg;
    logic          neg_reg;
    logic [PCW-1:0] cnt_reg;
    logic [VW-1:0] res_reg, out_val_reg;
    logic          res_status_reg, out_status_reg, m_valid_reg;

    logic [TW-1:0] time_mem [MEM_D];
    logic [VW-1:0] value_mem [MEM_D];
    logic [TW-1:0] t_rdata_reg;
    logic [VW-1:0] v_rdata_reg;

    function automatic logic [VW-1:0] flip(input logic [VW-1:0] v);
        return {~v[VW-1], v[VW-2:0]};
    endfunction

    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                              input logic [CW-1:0] k);
        logic [CW:0] s;
        s = (CW+1)'(head) + (CW+1)'(k);
        if (s >= (CW+1)'(RING_DEPTH)) begin
            s = s - (CW+1)'(RING_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    // channel decode
    logic [CHW+2:0] ch_wide;
    logic [CHW-1:0] ch_idx;
    logic           ch_ok;
    logic [AW-1:0]  head_cur;
    logic [CW-1:0]  count_cur;

    assign ch_wide   = {{CHW{1'b0}}, ch_reg};
    assign ch_idx    = ch_wide[CHW-1:0];
    assign ch_ok     = ch_wide < (CHW+3)'(NUM_CHANNELS);
    assign head_cur  = head_reg[ch_idx];
    assign count_cur = count_reg[ch_idx];

    logic [MAW-1:0] ch_base;
    assign ch_base = MAW'(ch_idx) * MAW'(RING_DEPTH);

    // query checks
    logic [TW-1:0] elapsed;
    logic          first_hit;
    assign elapsed   = now_reg - start_reg;
    assign first_hit = elapsed <= delay_reg;

    // search step
    logic          go_hi, search_cont;
    logic [CW-1:0] lo_n, hi_n, mid_n;
    logic [CW:0]   mid_sum;
    assign go_hi       = t_rdata_reg > ts_reg;
    assign lo_n        = go_hi ? lo_reg : i_reg;
    assign hi_n        = go_hi ? i_reg : hi_reg;
    assign search_cont = (t_rdata_reg != ts_reg) &&
                         ((CW+1)'(hi_n) > (CW+1)'(lo_n) + (CW+1)'(1));
    assign mid_sum     = ((CW+1)'(lo_n) + (CW+1)'(hi_n)) >> 1;
    assign mid_n       = mid_sum[CW-1:0];

    // read address
    logic [CW-1:0]  rd_k;
    logic [MAW-1:0] rd_addr;
    always_comb begin
        unique case (state_reg)
            ST_CHECK:  rd_k = first_hit ? '0 : count_cur - CW'(1);
            ST_RDLAST: rd_k = len_reg >> 1;
            ST_SEARCH: rd_k = search_cont ? mid_n : lo_n;
            ST_RDI:    rd_k = i_reg + CW'(1);
            default:   rd_k = '0;
        endcase
    end
    assign rd_addr = ch_base + MAW'(slot_of(head_cur, rd_k));

    // store write
    logic           store_ok, ring_full;
    logic [MAW-1:0] wr_addr;
    assign store_ok  = ch_ok && (now_reg >= start_reg);
    assign ring_full = count_cur >= CW'(RING_DEPTH);
    assign wr_addr   = ch_base + MAW'(slot_of(head_cur, ring_full ? '0 : count_cur));

    always_ff @(posedge aclk) begin
        if (state_reg == ST_STORE && store_ok) begin
            time_mem[wr_addr]  <= now_reg;
            value_mem[wr_addr] <= cur_reg;
        end
        t_rdata_reg <= time_mem[rd_addr];
        v_rdata_reg <= value_mem[rd_addr];
    end

    // interpolation setup
    logic          tneg, dneg, vneg;
    logic [TW-1:0] tdm, dtm;
    logic [VW-1:0] dvm;
    assign tneg = t1_reg < t0_reg;
    assign dneg = ts_reg < t0_reg;
    assign vneg = o1_reg < o0_reg;
    assign tdm  = tneg ? t0_reg - t1_reg : t1_reg - t0_reg;
    assign dtm  = dneg ? t0_reg - ts_reg : ts_reg - t0_reg;
    assign dvm  = vneg ? o0_reg - o1_reg : o1_reg - o0_reg;

    // divider step
    logic [TW:0] div_r2, div_diff;
    logic        div_ge;
    assign div_r2   = {rem_reg, prod_reg[P-1]};
    assign div_ge   = div_r2 >= {1'b0, dvs_reg};
    assign div_diff = div_r2 - {1'b0, dvs_reg};

    // saturation
    logic [VW-1:0] room, sat_o;
    logic [P:0]    q_up;
    assign room = {VW{1'b1}} - o0_reg;
    assign q_up = (P+1)'(q_reg) + (P+1)'(rem_reg != '0);
    always_comb begin
        if (!neg_reg) begin
            sat_o = (q_reg > P'(room)) ? {VW{1'b1}} : o0_reg + q_reg[VW-1:0];
        end else begin
            sat_o = (q_up > (P+1)'(o0_reg)) ? '0 : o0_reg - q_up[VW-1:0];
        end
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(OUT_W-VW-1){1'b0}}, out_status_reg, out_val_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            start_reg   <= '0;
            m_valid_reg <= 1'b0;
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                head_reg[c]  <= '0;
                count_reg[c] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                start_reg <= cfg_wr_data;
            end
            if (m_valid_reg && m_tready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        ch_reg    <= s_tuser[tdli_pkg::CHAN_W:1];
                        cur_reg   <= s_tdata[VW-1:0];
                        now_reg   <= s_tdata[VW+TW-1:VW];
                        delay_reg <= s_tdata[VW+2*TW-1:VW+TW];
                        limit_reg <= s_tdata[VW+3*TW-1:VW+2*TW];
                        state_reg <= (s_tuser[0] == tdli_pkg::MODE_STORE) ?
                                     ST_STORE : ST_CHECK;
                    end
                end
                ST_STORE: begin
                    if (store_ok) begin
                        if (ring_full) begin
                            head_reg[ch_idx] <= slot_of(head_cur, CW'(1));
                        end else begin
                            count_reg[ch_idx] <= count_cur + CW'(1);
                        end
                    end
                    state_reg <= ST_IDLE;
                end
                ST_CHECK: begin
                    priority if (!ch_ok || now_reg <= start_reg) begin
                        res_reg        <= cur_reg;
                        res_status_reg <= tdli_pkg::STATUS_OK;
                        state_reg      <= ST_DONE;
                    end else if (delay_reg[TW-1]) begin
                        res_reg        <= '0;
                        res_status_reg <= tdli_pkg::STATUS_NEG_DELAY;
                        state_reg      <= ST_DONE;
                    end else if (count_cur == '0) begin
                        res_reg        <= cur_reg;
                        res_status_reg <= tdli_pkg::STATUS_OK;
                        state_reg      <= ST_DONE;
                    end else if (first_hit) begin
                        res_reg        <= cur_reg;
                        res_status_reg <= tdli_pkg::STATUS_OK;
                        state_reg      <= ST_RDFIRST;
                    end else begin
                        res_reg        <= cur_reg;
                        res_status_reg <= tdli_pkg::STATUS_OK;
                        ts_reg         <= now_reg - delay_reg;
                        len_reg        <= count_cur;
                        state_reg      <= ST_RDLAST;
                    end
                end
                ST_RDFIRST: begin
                    res_reg   <= v_rdata_reg;
                    state_reg <= ST_DONE;
                end
                ST_RDLAST: begin
                    t0_reg <= t_rdata_reg;
                    o0_reg <= flip(v_rdata_reg);
                    if (ts_reg > t_rdata_reg) begin
                        // past the newest entry: the current sample is the upper point
                        t1_reg    <= now_reg;
                        o1_reg    <= flip(cur_reg);
                        state_reg <= ST_EVAL;
                    end else begin
                        lo_reg    <= '0;
                        hi_reg    <= len_reg;
                        i_reg     <= len_reg >> 1;
                        state_reg <= ST_SEARCH;
                    end
                end
                ST_SEARCH: begin
                    lo_reg <= lo_n;
                    hi_reg <= hi_n;
                    if (search_cont) begin
                        i_reg <= mid_n;
                    end else begin
                        i_reg     <= lo_n;
                        state_reg <= ST_RDI;
                    end
                end
                ST_RDI: begin
                    t0_reg <= t_rdata_reg;
                    o0_reg <= flip(v_rdata_reg);
                    // when delay equals the limit, drop entries older than the one before the lower bracket
                    if (i_reg != '0 && delay_reg == limit_reg) begin
                        head_reg[ch_idx]  <= slot_of(head_cur, i_reg - CW'(1));
                        count_reg[ch_idx] <= count_cur - (i_reg - CW'(1));
                    end
                    if ((CW+1)'(i_reg) + (CW+1)'(1) < (CW+1)'(len_reg)) begin
                        state_reg <= ST_RDI1;
                    end else begin
                        res_reg   <= v_rdata_reg;
                        state_reg <= ST_DONE;
                    end
                end
                ST_RDI1: begin
                    t1_reg    <= t_rdata_reg;
                    o1_reg    <= flip(v_rdata_reg);
                    state_reg <= ST_EVAL;
                end
                ST_EVAL: begin
                    priority if (t0_reg == ts_reg) begin
                        res_reg   <= flip(o0_reg);
                        state_reg <= ST_DONE;
                    end else if (t1_reg == ts_reg) begin
                        res_reg   <= flip(o1_reg);
                        state_reg <= ST_DONE;
                    end else if (tdm == '0) begin
                        res_reg   <= flip(o0_reg);
                        state_reg <= ST_DONE;
                    end else begin
                        a_reg     <= P'(dvm);
                        b_reg     <= dtm;
                        prod_reg  <= '0;
                        dvs_reg   <= tdm;
                        neg_reg   <= vneg ^ dneg ^ tneg;
                        cnt_reg   <= '0;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (b_reg[0]) begin
                        prod_reg <= prod_reg + a_reg;
                    end
                    a_reg <= a_reg << 1;
                    b_reg <= b_reg >> 1;
                    if (cnt_reg == PCW'(TW - 1)) begin
                        cnt_reg   <= '0;
                        rem_reg   <= '0;
                        q_reg     <= '0;
                        state_reg <= ST_DIV;
                    end else begin
                        cnt_reg <= cnt_reg + PCW'(1);
                    end
                end
                ST_DIV: begin
                    rem_reg  <= div_ge ? div_diff[TW-1:0] : div_r2[TW-1:0];
                    q_reg    <= {q_reg[P-2:0], div_ge};
                    prod_reg <= prod_reg << 1;
                    cnt_reg  <= cnt_reg + PCW'(1);
                    if (cnt_reg == PCW'(P - 1)) begin
                        state_reg <= ST_SAT;
                    end
                end
                ST_SAT: begin
                    res_reg   <= flip(sat_o);
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    // hold until the output register is free
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg    <= 1'b1;
                        out_val_reg    <= res_reg;
                        out_status_reg <= res_status_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `TDLI_ASSERT_IMP(a_search_bounds, state_reg == ST_SEARCH, (lo_reg < hi_reg) && (hi_reg <= len_reg))
    `TDLI_ASSERT_IMP(a_count_bound, (state_reg == ST_STORE) && ch_ok, count_cur <= CW'(RING_DEPTH))
    `TDLI_ASSERT_IMP(a_err_zero, m_tvalid && (m_tdata[VW] == tdli_pkg::STATUS_NEG_DELAY), m_tdata[VW-1:0] == '0)
    `TDLI_ASSERT_NXT(a_done_fire, (state_reg == ST_DONE) && m_tready, m_tvalid && (state_reg == ST_IDLE))

endmodule
